// File: rtl/psir_pkg.sv
// Shared types, constants and helper functions for the pad serial interface registers.
// Depends on nothing; the core and the bench refer to it by scoped names.
package psir_pkg;

  localparam int BufBytes  = 128;
  localparam int BufWords  = BufBytes / 4;
  localparam int BankDepth = BufWords / 2;
  localparam int BufIdxW   = $clog2(BufWords);
  localparam int BankAddrW = $clog2(BankDepth);
  localparam int NumChan   = 4;
  localparam int ChanW     = $clog2(NumChan);

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // word offsets (byte offset / 4)
  localparam logic [5:0] WO_CHAN_LAST = 6'h0B;
  localparam logic [5:0] WO_POLL      = 6'h0C;
  localparam logic [5:0] WO_CSR       = 6'h0D;
  localparam logic [5:0] WO_STATUS    = 6'h0E;
  localparam logic [5:0] WO_CLOCK     = 6'h0F;

  localparam logic [7:0] CMD_ID_LO  = 8'h00;
  localparam logic [7:0] CMD_ID_HI  = 8'hFF;
  localparam logic [7:0] CMD_POLL   = 8'h40;
  localparam logic [7:0] CMD_ORIG_A = 8'h41;
  localparam logic [7:0] CMD_ORIG_B = 8'h42;

  localparam logic [31:0] ID_WORD0     = 32'h0900_0000;
  localparam logic [31:0] ORIG_WORD0   = 32'h0080_8080;
  localparam logic [31:0] ORIG_WORD1   = 32'h8080_0000;
  localparam logic [31:0] NO_PAD_HI    = 32'h8000_0000;
  localparam logic [31:0] HI_READ_MASK = 32'h3FFF_FFFF;
  localparam logic [31:0] CSR_CLR_MASK = 32'hA000_0000;
  localparam logic [31:0] CSR_SET_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] ST_CLR_MASK  = 32'h0F0F_0F0F;
  localparam logic [31:0] ST_POLL_BIT  = 32'h2000_0000;
  localparam logic [31:0] ST_RDST_BIT  = 32'h0000_0020;
  localparam logic [31:0] ST_NORSP_BIT = 32'h0000_0008;

  typedef enum logic [1:0] {
    SLOT_OUT,
    SLOT_HI,
    SLOT_LO
  } slot_t;

  typedef struct packed {
    logic              operation;
    logic [7:0]        address;
    logic [31:0]       write_data;
    logic [15:0]       pad_buttons;
    logic signed [7:0] main_stick_x;
    logic signed [7:0] main_stick_y;
    logic signed [7:0] c_stick_x;
    logic signed [7:0] c_stick_y;
    logic [7:0]        left_trigger;
    logic [7:0]        right_trigger;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_raise;
    logic        irq_clear;
  } rsp_t;

  function automatic logic [31:0] pad_hi(req_t r);
    pad_hi = {3'b000, r.pad_buttons[12:8], 1'b1, r.pad_buttons[6:0],
              r.main_stick_x ^ 8'h80, r.main_stick_y ^ 8'h80};
  endfunction

  function automatic logic [31:0] pad_lo(req_t r);
    pad_lo = {r.c_stick_x ^ 8'h80, r.c_stick_y ^ 8'h80, r.left_trigger, r.right_trigger};
  endfunction

  function automatic logic [ChanW-1:0] chan_of(logic [3:0] widx);
    case (widx)
      4'd0, 4'd1, 4'd2:   chan_of = 2'd0;
      4'd3, 4'd4, 4'd5:   chan_of = 2'd1;
      4'd6, 4'd7, 4'd8:   chan_of = 2'd2;
      default:            chan_of = 2'd3;
    endcase
  endfunction

  function automatic slot_t slot_of(logic [3:0] widx);
    case (widx)
      4'd0, 4'd3, 4'd6, 4'd9:  slot_of = SLOT_OUT;
      4'd1, 4'd4, 4'd7, 4'd10: slot_of = SLOT_HI;
      default:                 slot_of = SLOT_LO;
    endcase
  endfunction

  // bit of a channel's byte lane in the status register
  function automatic logic [31:0] lane_bit(logic [31:0] base, logic [ChanW-1:0] ch);
    lane_bit = base << {~ch, 3'b000};
  endfunction

endpackage

// File: rtl/psir_ram.sv
// Generic synchronous RAM: one write port, one read port with registered data.
// Depends on nothing.
module psir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pad_serial_interface_registers_core.sv
// Top level of the pad serial interface registers: bus decode, control registers
// and the I/O buffer held in two RAM banks (even and odd words). Uses psir_pkg, psir_ram.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// One item per cycle while req_stall is low; each result appears in the cycle after its item is taken.
// Registers update at the accepting edge; buffer reads return the bank RAM data,
// registered in the RAM at that edge. A transfer clears the buffer at once through per-word valid bits.
// Reset clears the control registers, valid bits and s1_valid; no clearing pass is needed.
// While rsp_stall holds a result, req_stall rises and the RAM read data is held.
module pad_serial_interface_registers_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  psir_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output psir_pkg::rsp_t rsp
);

  logic [31:0] chan_out [psir_pkg::NumChan];
  logic [31:0] chan_out_next [psir_pkg::NumChan];
  logic [31:0] poll, poll_next;
  logic [31:0] csr, csr_next;
  logic [31:0] status, status_next;
  logic [31:0] clk_sel, clk_sel_next;
  logic [7:0]  cmd_byte, cmd_byte_next;
  logic [psir_pkg::BufWords-1:0] buf_vld, buf_vld_next;

  logic        s1_valid;
  logic [31:0] s1_rd, s1_rd_next;
  logic        s1_buf, s1_buf_next;
  logic        s1_bank, s1_bank_next;
  logic        s1_hit, s1_hit_next;
  logic        s1_raise, s1_raise_next;
  logic        s1_clr, s1_clr_next;

  logic        accept;
  logic [5:0]  widx;
  logic [psir_pkg::BufIdxW-1:0] bidx;
  logic [psir_pkg::ChanW-1:0]   ch, xfer_ch;
  psir_pkg::slot_t              slot;
  logic [31:0] hi_word, lo_word;

  logic                           we_even, we_odd, re_buf;
  logic [psir_pkg::BankAddrW-1:0] waddr;
  logic [31:0]                    wdata_even, wdata_odd;
  logic [31:0]                    rdata_even, rdata_odd;

  assign accept    = req_valid && !req_stall;
  assign req_stall = s1_valid && rsp_stall;
  assign widx      = req.address[7:2];
  assign bidx      = widx[psir_pkg::BufIdxW-1:0];
  assign ch        = psir_pkg::chan_of(widx[3:0]);
  assign slot      = psir_pkg::slot_of(widx[3:0]);
  assign hi_word   = psir_pkg::pad_hi(req);
  assign lo_word   = psir_pkg::pad_lo(req);

  always_comb begin
    for (int i = 0; i < psir_pkg::NumChan; i++) begin
      chan_out_next[i] = chan_out[i];
    end
    poll_next     = poll;
    csr_next      = csr;
    status_next   = status;
    clk_sel_next  = clk_sel;
    cmd_byte_next = cmd_byte;
    buf_vld_next  = buf_vld;
    s1_rd_next    = '0;
    s1_buf_next   = 1'b0;
    s1_bank_next  = bidx[0];
    s1_hit_next   = buf_vld[bidx];
    s1_raise_next = 1'b0;
    s1_clr_next   = 1'b0;
    we_even       = 1'b0;
    we_odd        = 1'b0;
    re_buf        = 1'b0;
    waddr         = bidx[psir_pkg::BufIdxW-1:1];
    wdata_even    = req.write_data;
    wdata_odd     = req.write_data;
    xfer_ch       = csr_next[2:1];

    if (accept) begin
      if (widx <= psir_pkg::WO_CHAN_LAST) begin
        if (req.operation == psir_pkg::OP_WRITE) begin
          if (slot == psir_pkg::SLOT_OUT) begin
            chan_out_next[ch] = req.write_data;
          end
        end else begin
          case (slot)
            psir_pkg::SLOT_OUT: s1_rd_next = chan_out[ch];
            psir_pkg::SLOT_HI: begin
              status_next = status & ~psir_pkg::lane_bit(psir_pkg::ST_RDST_BIT, ch);
              s1_rd_next  = (ch == '0) ? (hi_word & psir_pkg::HI_READ_MASK)
                                       : psir_pkg::NO_PAD_HI;
            end
            default: s1_rd_next = (ch == '0) ? lo_word : '0;
          endcase
        end
      end else if (widx[5]) begin
        if (req.operation == psir_pkg::OP_WRITE) begin
          we_even       = !bidx[0];
          we_odd        = bidx[0];
          buf_vld_next[bidx] = 1'b1;
          if (bidx == '0) begin
            cmd_byte_next = req.write_data[31:24];
          end
        end else begin
          re_buf      = 1'b1;
          s1_buf_next = 1'b1;
        end
      end else begin
        case (widx)
          psir_pkg::WO_POLL: begin
            if (req.operation == psir_pkg::OP_WRITE) poll_next = req.write_data;
            else s1_rd_next = poll;
          end
          psir_pkg::WO_CSR: begin
            if (req.operation == psir_pkg::OP_WRITE) begin
              csr_next = (csr & ~(req.write_data & psir_pkg::CSR_CLR_MASK))
                       | (req.write_data & psir_pkg::CSR_SET_MASK);
              s1_clr_next = req.write_data[31];
              xfer_ch     = csr_next[2:1];
              if (req.write_data[0]) begin
                buf_vld_next = '0;
                if (xfer_ch == '0) begin
                  we_even = 1'b1;
                  we_odd  = 1'b1;
                  waddr   = '0;
                  buf_vld_next[0] = 1'b1;
                  buf_vld_next[1] = 1'b1;
                  case (cmd_byte)
                    psir_pkg::CMD_ID_LO, psir_pkg::CMD_ID_HI: begin
                      wdata_even = psir_pkg::ID_WORD0;
                      wdata_odd  = '0;
                    end
                    psir_pkg::CMD_POLL: begin
                      wdata_even = hi_word;
                      wdata_odd  = lo_word;
                    end
                    psir_pkg::CMD_ORIG_A, psir_pkg::CMD_ORIG_B: begin
                      wdata_even = psir_pkg::ORIG_WORD0;
                      wdata_odd  = psir_pkg::ORIG_WORD1;
                    end
                    default: begin
                      wdata_even = '0;
                      wdata_odd  = '0;
                    end
                  endcase
                  cmd_byte_next = wdata_even[31:24];
                end else begin
                  cmd_byte_next = '0;
                  if (cmd_byte != psir_pkg::CMD_POLL) begin
                    status_next = status
                                | psir_pkg::lane_bit(psir_pkg::ST_NORSP_BIT, xfer_ch);
                  end
                end
                csr_next[0]   = 1'b0;
                csr_next[31]  = 1'b1;
                s1_raise_next = csr_next[30];
              end
            end else begin
              s1_rd_next = csr;
            end
          end
          psir_pkg::WO_STATUS: begin
            if (req.operation == psir_pkg::OP_WRITE) begin
              status_next = status & ~(req.write_data & psir_pkg::ST_CLR_MASK);
              if (req.write_data[31]) status_next[31] = 1'b0;
            end else begin
              status_next = poll[7] ? (status | psir_pkg::ST_POLL_BIT) : status;
              s1_rd_next  = status_next;
            end
          end
          psir_pkg::WO_CLOCK: begin
            if (req.operation == psir_pkg::OP_WRITE) clk_sel_next = req.write_data;
            else s1_rd_next = clk_sel;
          end
          default: s1_rd_next = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < psir_pkg::NumChan; i++) begin
        chan_out[i] <= '0;
      end
      poll     <= '0;
      csr      <= '0;
      status   <= '0;
      clk_sel  <= '0;
      cmd_byte <= '0;
      buf_vld  <= '0;
      s1_valid <= 1'b0;
    end else begin
      for (int i = 0; i < psir_pkg::NumChan; i++) begin
        chan_out[i] <= chan_out_next[i];
      end
      poll     <= poll_next;
      csr      <= csr_next;
      status   <= status_next;
      clk_sel  <= clk_sel_next;
      cmd_byte <= cmd_byte_next;
      buf_vld  <= buf_vld_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (!rsp_stall) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rd    <= s1_rd_next;
      s1_buf   <= s1_buf_next;
      s1_bank  <= s1_bank_next;
      s1_hit   <= s1_hit_next;
      s1_raise <= s1_raise_next;
      s1_clr   <= s1_clr_next;
    end
  end

  psir_ram #(
    .WIDTH(32),
    .DEPTH(psir_pkg::BankDepth)
  ) u_bank_even (
    .clk  (clk),
    .we   (we_even),
    .waddr(waddr),
    .wdata(wdata_even),
    .re   (re_buf),
    .raddr(bidx[psir_pkg::BufIdxW-1:1]),
    .rdata(rdata_even)
  );

  psir_ram #(
    .WIDTH(32),
    .DEPTH(psir_pkg::BankDepth)
  ) u_bank_odd (
    .clk  (clk),
    .we   (we_odd),
    .waddr(waddr),
    .wdata(wdata_odd),
    .re   (re_buf),
    .raddr(bidx[psir_pkg::BufIdxW-1:1]),
    .rdata(rdata_odd)
  );

  assign rsp_valid     = s1_valid;
  assign rsp.read_data = !s1_buf ? s1_rd
                       : (!s1_hit ? '0 : (s1_bank ? rdata_odd : rdata_even));
  assign rsp.irq_raise = s1_raise;
  assign rsp.irq_clear = s1_clr;

endmodule

// File: tb/tb_pad_serial_interface_registers_core.sv
// Self-checking bench for pad_serial_interface_registers_core: bus accesses, pad reads and transfers.
// Holds its own register and buffer model, with bursty requests and a stalling receiver.
// Depends on psir_pkg and the core only.
module tb_pad_serial_interface_registers_core;

  localparam int RandItems = 1250;
  localparam int IdleLimit = 5000;

  localparam logic [7:0] A_CH0_HI  = 8'h04;
  localparam logic [7:0] A_CH0_LO  = 8'h08;
  localparam logic [7:0] A_CH1_HI  = 8'h10;
  localparam logic [7:0] A_CH3_OUT = 8'h24;
  localparam logic [7:0] A_CH3_LO  = 8'h2C;
  localparam logic [7:0] A_POLL    = {psir_pkg::WO_POLL, 2'b00};
  localparam logic [7:0] A_CSR     = {psir_pkg::WO_CSR, 2'b00};
  localparam logic [7:0] A_STATUS  = {psir_pkg::WO_STATUS, 2'b00};
  localparam logic [7:0] A_CLOCK   = {psir_pkg::WO_CLOCK, 2'b00};
  localparam logic [7:0] A_GAP     = 8'h40;
  localparam logic [7:0] A_BUF     = 8'h80;

  localparam logic [31:0] IRQ_EN     = 32'h4000_0000;
  localparam logic [31:0] CHAN_FIELD = 32'h0000_0006;

  typedef struct {
    psir_pkg::req_t a;
    logic known;
    psir_pkg::rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  psir_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  psir_pkg::rsp_t rsp;

  logic [31:0] ch_out [psir_pkg::NumChan] = '{default: '0};
  logic [31:0] buf_w [psir_pkg::BufWords] = '{default: '0};
  logic [31:0] poll_w = '0;
  logic [31:0] csr_w = '0;
  logic [31:0] stat_w = '0;
  logic [31:0] clk_sel_w = '0;

  psir_pkg::rsp_t reply_q [$];
  psir_pkg::req_t plan_q [$];
  row_t dir_rows [$];

  int bad_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int mode = 0;
  int mode_left = 0;

  pad_serial_interface_registers_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] hi_word(psir_pkg::req_t a);
    logic [7:0] sx, sy;
    sx = a.main_stick_x + 8'd128;
    sy = a.main_stick_y + 8'd128;
    return {3'b000, a.pad_buttons[12:8], 1'b1, a.pad_buttons[6:0], sx, sy};
  endfunction

  function automatic logic [31:0] lo_word(psir_pkg::req_t a);
    logic [7:0] cx, cy;
    cx = a.c_stick_x + 8'd128;
    cy = a.c_stick_y + 8'd128;
    return {cx, cy, a.left_trigger, a.right_trigger};
  endfunction

  function automatic logic [31:0] chan_lane(logic [31:0] b, logic [1:0] c);
    return b << (8 * (3 - c));
  endfunction

  function automatic psir_pkg::rsp_t bus_access(psir_pkg::req_t a);
    logic [5:0] wo;
    logic [1:0] ch, xch;
    logic [31:0] d, rd;
    logic [7:0] cmd;
    psir_pkg::rsp_t r;
    wo = a.address[7:2];
    d = a.write_data;
    rd = '0;
    r = '0;
    if (wo <= psir_pkg::WO_CHAN_LAST) begin
      ch = 2'(wo / 6'd3);
      case (wo % 6'd3)
        0: begin
          if (a.operation == psir_pkg::OP_WRITE) ch_out[ch] = d;
          else rd = ch_out[ch];
        end
        1: begin
          if (a.operation == psir_pkg::OP_READ) begin
            stat_w &= ~chan_lane(psir_pkg::ST_RDST_BIT, ch);
            rd = (ch == 2'd0) ? (hi_word(a) & psir_pkg::HI_READ_MASK) : psir_pkg::NO_PAD_HI;
          end
        end
        default: begin
          if (a.operation == psir_pkg::OP_READ) rd = (ch == 2'd0) ? lo_word(a) : '0;
        end
      endcase
    end else if (wo == psir_pkg::WO_POLL) begin
      if (a.operation == psir_pkg::OP_WRITE) poll_w = d;
      else rd = poll_w;
    end else if (wo == psir_pkg::WO_CSR) begin
      if (a.operation == psir_pkg::OP_WRITE) begin
        csr_w &= ~(d & psir_pkg::CSR_CLR_MASK);
        csr_w |= d & psir_pkg::CSR_SET_MASK;
        if (d[31]) begin
          csr_w[31] = 1'b0;
          r.irq_clear = 1'b1;
        end
        if (d[0]) begin
          xch = csr_w[2:1];
          cmd = buf_w[0][31:24];
          foreach (buf_w[i]) buf_w[i] = '0;
          case (cmd)
            psir_pkg::CMD_ID_LO, psir_pkg::CMD_ID_HI: begin
              if (xch == 2'd0) buf_w[0] = psir_pkg::ID_WORD0;
              else stat_w |= chan_lane(psir_pkg::ST_NORSP_BIT, xch);
            end
            psir_pkg::CMD_POLL: begin
              if (xch == 2'd0) begin
                buf_w[0] = hi_word(a);
                buf_w[1] = lo_word(a);
              end
            end
            psir_pkg::CMD_ORIG_A, psir_pkg::CMD_ORIG_B: begin
              if (xch == 2'd0) begin
                buf_w[0] = psir_pkg::ORIG_WORD0;
                buf_w[1] = psir_pkg::ORIG_WORD1;
              end else begin
                stat_w |= chan_lane(psir_pkg::ST_NORSP_BIT, xch);
              end
            end
            default: begin
              if (xch != 2'd0) stat_w |= chan_lane(psir_pkg::ST_NORSP_BIT, xch);
            end
          endcase
          csr_w[0] = 1'b0;
          csr_w[31] = 1'b1;
          r.irq_raise = csr_w[30];
        end
      end else begin
        rd = csr_w;
      end
    end else if (wo == psir_pkg::WO_STATUS) begin
      if (a.operation == psir_pkg::OP_WRITE) begin
        stat_w &= ~(d & psir_pkg::ST_CLR_MASK);
        if (d[31]) stat_w[31] = 1'b0;
      end else begin
        if (poll_w[7]) stat_w |= psir_pkg::ST_POLL_BIT;
        rd = stat_w;
      end
    end else if (wo == psir_pkg::WO_CLOCK) begin
      if (a.operation == psir_pkg::OP_WRITE) clk_sel_w = d;
      else rd = clk_sel_w;
    end else if (wo[5]) begin
      if (a.operation == psir_pkg::OP_WRITE) buf_w[wo[4:0]] = d;
      else rd = buf_w[wo[4:0]];
    end
    r.read_data = (a.operation == psir_pkg::OP_WRITE) ? '0 : rd;
    return r;
  endfunction

  function automatic psir_pkg::req_t with_pad(psir_pkg::req_t a, int sel);
    case (sel)
      0: begin
        a.pad_buttons = 16'h0000;
        a.main_stick_x = -8'sd128;
        a.main_stick_y = -8'sd128;
        a.c_stick_x = -8'sd128;
        a.c_stick_y = -8'sd128;
        a.left_trigger = 8'h00;
        a.right_trigger = 8'h00;
      end
      1: begin
        a.pad_buttons = 16'hFFFF;
        a.main_stick_x = 8'sd127;
        a.main_stick_y = 8'sd127;
        a.c_stick_x = 8'sd127;
        a.c_stick_y = 8'sd127;
        a.left_trigger = 8'hFF;
        a.right_trigger = 8'hFF;
      end
      default: begin
        a.pad_buttons = 16'hA5A5;
        a.main_stick_x = -8'sd1;
        a.main_stick_y = 8'sd1;
        a.c_stick_x = 8'sd100;
        a.c_stick_y = -8'sd100;
        a.left_trigger = 8'h5A;
        a.right_trigger = 8'hA5;
      end
    endcase
    return a;
  endfunction

  task automatic add_row(logic op, logic [7:0] addr, logic [31:0] data, int sel,
                         logic known, psir_pkg::rsp_t want);
    row_t row;
    row.a = '0;
    row.a.operation = op;
    row.a.address = addr;
    row.a.write_data = data;
    row.a = with_pad(row.a, sel);
    row.known = known;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  function automatic logic [31:0] csr_bits(int ph, logic [31:0] d);
    if (ph == 0) d &= ~(IRQ_EN | CHAN_FIELD);
    else if (ph == 1) d &= ~CHAN_FIELD;
    return d;
  endfunction

  function automatic psir_pkg::req_t random_access(int ph);
    psir_pkg::req_t a;
    int pick;
    a.operation = 1'($urandom_range(0, 1));
    a.write_data = $urandom;
    a.pad_buttons = 16'($urandom);
    a.main_stick_x = 8'($urandom);
    a.main_stick_y = 8'($urandom);
    a.c_stick_x = 8'($urandom);
    a.c_stick_y = 8'($urandom);
    a.left_trigger = 8'($urandom);
    a.right_trigger = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) a.address = 8'($urandom_range(0, 8'h2F));
    else if (pick < 55) a.address = 8'($urandom_range(8'h30, 8'h3F));
    else if (pick < 62) a.address = 8'($urandom_range(8'h40, 8'h7F));
    else a.address = 8'($urandom_range(8'h80, 8'hFF));
    if (a.address[7:2] == psir_pkg::WO_CSR && a.operation == psir_pkg::OP_WRITE)
      a.write_data = csr_bits(ph, a.write_data);
    return a;
  endfunction

  task automatic queue_transfer(int ph);
    psir_pkg::req_t a;
    logic [7:0] cmd;
    int reads;
    case ($urandom_range(0, 5))
      0: cmd = psir_pkg::CMD_ID_LO;
      1: cmd = psir_pkg::CMD_ID_HI;
      2: cmd = psir_pkg::CMD_POLL;
      3: cmd = psir_pkg::CMD_ORIG_A;
      4: cmd = psir_pkg::CMD_ORIG_B;
      default: cmd = 8'($urandom);
    endcase
    a = random_access(ph);
    a.operation = psir_pkg::OP_WRITE;
    a.address = {A_BUF[7:2], 2'($urandom)};
    a.write_data = {cmd, 24'($urandom)};
    plan_q.push_back(a);
    if ($urandom_range(0, 3) == 0) begin
      a = random_access(ph);
      a.operation = psir_pkg::OP_WRITE;
      a.address = 8'($urandom_range(8'h84, 8'hFF));
      plan_q.push_back(a);
    end
    a = random_access(ph);
    a.operation = psir_pkg::OP_WRITE;
    a.address = {A_CSR[7:2], 2'($urandom)};
    a.write_data = csr_bits(ph, $urandom) | 32'h1;
    plan_q.push_back(a);
    reads = $urandom_range(1, 3);
    for (int k = 0; k < reads; k++) begin
      a = random_access(ph);
      a.operation = psir_pkg::OP_READ;
      a.address = A_BUF + 8'(4 * k) + 8'($urandom_range(0, 3));
      plan_q.push_back(a);
    end
    if ($urandom_range(0, 2) == 0) begin
      a = random_access(ph);
      a.operation = psir_pkg::OP_READ;
      a.address = A_STATUS;
      plan_q.push_back(a);
    end
  endtask

  task automatic offer(psir_pkg::req_t a, logic known, psir_pkg::rsp_t want, logic hold);
    psir_pkg::rsp_t got;
    int g;
    req <= a;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    got = bus_access(a);
    reply_q.push_back(known ? want : got);
    if (hold) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while (reply_q.size() != 0) @(posedge clk);
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (g > 0) begin
        req_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic flag_bad(string what, psir_pkg::rsp_t w, psir_pkg::rsp_t g);
    bad_count++;
    if (bad_count <= 10)
      $display("%s: expected data %h raise %b clear %b, got data %h raise %b clear %b",
               what, w.read_data, w.irq_raise, w.irq_clear,
               g.read_data, g.irq_raise, g.irq_clear);
  endtask

  always @(posedge clk) begin : rx
    psir_pkg::rsp_t w;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (reply_q.size() == 0) begin
          flag_bad("result with nothing outstanding", '0, rsp);
        end else begin
          w = reply_q.pop_front();
          if (rsp.read_data !== w.read_data || rsp.irq_raise !== w.irq_raise ||
              rsp.irq_clear !== w.irq_clear)
            flag_bad("mismatch", w, rsp);
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      case (mode)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 20);
            rsp_stall <= 1'b1;
          end else begin
            rsp_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("pad_serial_interface_registers_core test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : feed
    int ph;
    add_row(psir_pkg::OP_READ, A_CSR, 32'h0, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_STATUS, 32'h0, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CH0_HI, 32'h0, 1, 1'b1, {32'h1FFF_FFFF, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CH0_LO, 32'h0, 1, 1'b1, {32'hFFFF_FFFF, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CH0_HI, 32'h0, 0, 1'b1, {32'h0080_0000, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CH1_HI, 32'h0, 2, 1'b1, {psir_pkg::NO_PAD_HI, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_CH3_OUT, 32'hFFFF_FFFF, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CH3_OUT + 8'd3, 32'h0, 2, 1'b1,
            {32'hFFFF_FFFF, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_CH3_LO, 32'hFFFF_FFFF, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_GAP, 32'hFFFF_FFFF, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_GAP + 8'h3D, 32'h0, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_POLL, 32'h0000_0080, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_STATUS, 32'h0, 2, 1'b1, {psir_pkg::ST_POLL_BIT, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_STATUS, 32'hFFFF_FFFF, 2, 1'b0, '0);
    add_row(psir_pkg::OP_WRITE, A_CLOCK, 32'hFFFF_FFFF, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_CLOCK, 32'h0, 2, 1'b1, {32'hFFFF_FFFF, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_BUF, {psir_pkg::CMD_POLL, 24'h0}, 2, 1'b1,
            {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_CSR, 32'h0000_0001, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_BUF, 32'h0, 0, 1'b0, '0);
    add_row(psir_pkg::OP_WRITE, A_BUF, {psir_pkg::CMD_ID_HI, 24'hFFFFFF}, 2, 1'b1,
            {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_CSR, 32'h8000_0001, 2, 1'b1, {32'h0, 1'b0, 1'b1});
    add_row(psir_pkg::OP_READ, A_BUF, 32'h0, 2, 1'b1, {psir_pkg::ID_WORD0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_BUF, {psir_pkg::CMD_ORIG_A, 24'h0}, 2, 1'b1,
            {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_WRITE, A_CSR, 32'h0000_0001, 2, 1'b1, {32'h0, 1'b0, 1'b0});
    add_row(psir_pkg::OP_READ, A_BUF + 8'h4, 32'h0, 2, 1'b1,
            {psir_pkg::ORIG_WORD1, 1'b0, 1'b0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer(dir_rows[i].a, dir_rows[i].known, dir_rows[i].want, 1'b0);

    for (int n = 0; n < RandItems; n++) begin
      ph = (n < 500) ? 0 : (n < 900) ? 1 : 2;
      if (plan_q.size() == 0) begin
        if ($urandom_range(0, 99) < 45) queue_transfer(ph);
        else plan_q.push_back(random_access(ph));
      end
      offer(plan_q.pop_front(), 1'b0, '0, n == 899);
    end
    req_valid <= 1'b0;

    while (reply_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (bad_count == 0 && reply_q.size() == 0)
      $display("pad_serial_interface_registers_core test passed");
    else
      $display("pad_serial_interface_registers_core test failed");
    $finish;
  end

endmodule
